// File: rtl/lebd_pkg.sv
// Shared types, codes and helper functions of the LEB128 stream decoder.
`default_nettype none

package lebd_pkg;

    // Value kinds, selected by the command on the first byte of a value
    typedef enum logic [1:0] {
        KIND_U32 = 2'd0,
        KIND_I32 = 2'd1,
        KIND_U64 = 2'd2,
        KIND_I64 = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERLONG = 2'd1,
        ST_RANGE    = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    localparam logic [3:0] MAX_LEN_32 = 4'd5;
    localparam logic [3:0] MAX_LEN_64 = 4'd10;

    localparam logic [7:0] CONT_BIT    = 8'h80;
    localparam logic [7:0] UPPER_32    = 8'hF8;
    localparam logic [7:0] UPPER_64    = 8'hFF;
    localparam logic [7:0] LEGAL_U32   = 8'h08;
    localparam logic [7:0] LEGAL_I32   = 8'h78;
    localparam logic [7:0] LEGAL_U64   = 8'h01;
    localparam logic [7:0] LEGAL_I64   = 8'h7F;
    localparam logic [63:0] LOW_WORD   = 64'h0000_0000_FFFF_FFFF;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic       last_in_buffer;
    } lebd_in_t;

    typedef struct packed {
        logic [63:0] value;
        logic [3:0]  byte_count;
        status_t     status;
    } lebd_out_t;

    // One classified byte handed from the front to the back
    typedef struct packed {
        kind_t      kind;
        logic [3:0] count;   // position of this byte in its value, 1..10
        logic [6:0] group;   // payload seven bits
        logic       ends;    // this byte closes the value
        status_t    status;
    } lebd_op_t;

    // Bit offset of the group at a given byte position
    function automatic logic [5:0] group_shift(input logic [3:0] count);
        logic [5:0] sh;
        case (count)
            4'd1:    sh = 6'd0;
            4'd2:    sh = 6'd7;
            4'd3:    sh = 6'd14;
            4'd4:    sh = 6'd21;
            4'd5:    sh = 6'd28;
            4'd6:    sh = 6'd35;
            4'd7:    sh = 6'd42;
            4'd8:    sh = 6'd49;
            4'd9:    sh = 6'd56;
            4'd10:   sh = 6'd63;
            default: sh = 6'd0;
        endcase
        return sh;
    endfunction

    // Mask of the bits filled by count groups
    function automatic logic [63:0] low_mask(input logic [3:0] count);
        logic [63:0] m;
        case (count)
            4'd1:    m = 64'h0000_0000_0000_007F;
            4'd2:    m = 64'h0000_0000_0000_3FFF;
            4'd3:    m = 64'h0000_0000_001F_FFFF;
            4'd4:    m = 64'h0000_0000_0FFF_FFFF;
            4'd5:    m = 64'h0000_0007_FFFF_FFFF;
            4'd6:    m = 64'h0000_03FF_FFFF_FFFF;
            4'd7:    m = 64'h0001_FFFF_FFFF_FFFF;
            4'd8:    m = 64'h00FF_FFFF_FFFF_FFFF;
            4'd9:    m = 64'h7FFF_FFFF_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/leb128_stream_decoder.sv
// Top level of the LEB128 stream decoder: front, queue and back joined together.
//
//  channel  dir  handshake          beat payload (lebd_pkg)
//  s_       in   s_valid/s_ready    lebd_in_t  {command, data_byte, last_in_buffer}
//  m_       out  m_valid/m_ready    lebd_out_t {value, byte_count, status}
//
// One byte per cycle is taken in steady flow. A result is loaded into the output
// register after the beat that ends its value has passed through the queue, and the
// consumer takes it from that register. Throughput is set by the back end, which
// retires one queued byte per cycle unless that byte ends a value and the output is held.
// Reset (aresetn low at a clock edge) empties the queue and the output register and
// clears position, kind, accumulator and drop mode.
// A stalled m_ready holds the result register; the back then stops only on a byte
// that ends a value, and s_ready falls once the queue is full.
`default_nettype none

module leb128_stream_decoder
    import lebd_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire lebd_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output lebd_out_t      m_data
);

    // front to queue
    logic     push_valid, push_ready;
    lebd_op_t push_op;
    // queue to back
    logic     pop_valid, pop_ready;
    lebd_op_t pop_op;

    // Classify each beat: position, latched kind, length and range checks, drop mode
    lebd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    // Decouple the two sides so an output stall does not reach the input at once
    lebd_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // Accumulate groups, extend the finished value and hold it for the consumer
    lebd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // An error result always carries a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK) || (m_data.value == 64'd0))
        else $error("error result with non-zero value");

    // Byte count stays within one to ten
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_count != 4'd0) && (m_data.byte_count <= MAX_LEN_64))
        else $error("byte count out of range");

    // Overlong and out-of-range only ever occur at a maximum-length byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == ST_OVERLONG || m_data.status == ST_RANGE)) |->
        (m_data.byte_count == MAX_LEN_32) || (m_data.byte_count == MAX_LEN_64))
        else $error("length error away from maximum length");

endmodule

`default_nettype wire

// File: rtl/lebd_front.sv
// Front end: accepts bytes, tracks value position and drop mode, classifies each byte.
`default_nettype none

module lebd_front
    import lebd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire lebd_in_t s_data,
    output logic          push_valid,
    input  wire logic     push_ready,
    output lebd_op_t      push_op
);

    logic [3:0] bytes_seen_reg, bytes_seen_next;
    kind_t      kind_reg, kind_next;
    logic       discarding_reg, discarding_next;

    kind_t      kind;
    logic [3:0] count;
    logic       is64, sgn, more, at_max, range_bad, ends;
    logic [7:0] upper, legal;
    status_t    status;
    logic       accept;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    always_comb begin
        kind   = (bytes_seen_reg == 4'd0) ? kind_t'(s_data.command) : kind_reg;
        count  = bytes_seen_reg + 4'd1;
        is64   = (kind == KIND_U64) || (kind == KIND_I64);
        sgn    = (kind == KIND_I32) || (kind == KIND_I64);
        more   = (s_data.data_byte & CONT_BIT) != 8'h00;
        at_max = is64 ? (count == MAX_LEN_64) : (count == MAX_LEN_32);

        upper = s_data.data_byte & (is64 ? UPPER_64 : UPPER_32);
        legal = is64 ? (sgn ? LEGAL_I64 : LEGAL_U64) : (sgn ? LEGAL_I32 : LEGAL_U32);
        range_bad = (upper != 8'h00) && (upper != legal);

        if (at_max) begin
            ends   = 1'b1;
            status = more ? ST_OVERLONG : (range_bad ? ST_RANGE : ST_OK);
        end else if (more) begin
            ends   = s_data.last_in_buffer;
            status = s_data.last_in_buffer ? ST_TRUNC : ST_OK;
        end else begin
            ends   = 1'b1;
            status = ST_OK;
        end
    end

    assign push_valid     = s_valid && !discarding_reg;
    assign push_op.kind   = kind;
    assign push_op.count  = count;
    assign push_op.group  = s_data.data_byte[6:0];
    assign push_op.ends   = ends;
    assign push_op.status = status;

    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        kind_next       = kind_reg;
        discarding_next = discarding_reg;
        if (accept) begin
            if (discarding_reg) begin
                // drop until the buffer ends
                if (s_data.last_in_buffer) begin
                    discarding_next = 1'b0;
                end
            end else begin
                kind_next = kind;
                if (ends) begin
                    bytes_seen_next = 4'd0;
                    discarding_next = (status != ST_OK) && !s_data.last_in_buffer;
                end else begin
                    bytes_seen_next = count;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= 4'd0;
            kind_reg       <= KIND_U32;
            discarding_reg <= 1'b0;
        end else begin
            bytes_seen_reg <= bytes_seen_next;
            kind_reg       <= kind_next;
            discarding_reg <= discarding_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lebd_queue.sv
// Short queue of classified bytes between the front and the back.
`default_nettype none

module lebd_queue
    import lebd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH   // 2 or more
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire lebd_op_t push_op,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output lebd_op_t      pop_op
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lebd_op_t        mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lebd_back.sv
// Back end: gathers seven-bit groups, extends finished values, holds the result register.
`default_nettype none

module lebd_back
    import lebd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     pop_valid,
    output logic          pop_ready,
    input  wire lebd_op_t pop_op,
    output logic          m_valid,
    input  wire logic     m_ready,
    output lebd_out_t     m_data
);

    logic [63:0] acc_reg, acc_next;
    logic        m_valid_reg, m_valid_next;
    lebd_out_t   m_data_reg, m_data_next;

    logic [63:0] acc_new, keep, value;
    logic        is64, sgn, fill, out_free, do_pop;

    assign out_free  = !m_valid_reg || m_ready;
    assign pop_ready = !pop_op.ends || out_free;
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        is64    = (pop_op.kind == KIND_U64) || (pop_op.kind == KIND_I64);
        sgn     = (pop_op.kind == KIND_I32) || (pop_op.kind == KIND_I64);
        acc_new = acc_reg | (64'(pop_op.group) << group_shift(pop_op.count));

        if (is64 && pop_op.count == MAX_LEN_64) begin
            keep = '1;
            fill = 1'b0;
        end else if (!is64 && pop_op.count == MAX_LEN_32) begin
            keep = LOW_WORD;
            fill = sgn && pop_op.group[3];
        end else begin
            keep = low_mask(pop_op.count);
            fill = sgn && pop_op.group[6];
        end

        if (pop_op.status != ST_OK) begin
            value = '0;
        end else begin
            value = (acc_new & keep) | (fill ? ~keep : '0);
        end
    end

    always_comb begin
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (do_pop) begin
            if (pop_op.ends) begin
                acc_next               = '0;
                m_valid_next           = 1'b1;
                m_data_next.value      = value;
                m_data_next.byte_count = pop_op.count;
                m_data_next.status     = pop_op.status;
            end else begin
                acc_next = acc_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
